@@ src/osa_pkg.sv @@
`timescale 1ns / 1ps
package osa_pkg;

  localparam int MAX_DIM = 64;
  localparam int ADDR_W = $clog2(MAX_DIM);
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_SIZE);

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  // smallest magnitude whose 2^-t reaches 2^-17
  localparam logic [40:0] EXP_MAG_LIMIT = 41'd772248;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;

  localparam logic signed [39:0] SCORE_MIN = {1'b1, 39'd0};
  localparam logic signed [39:0] SCORE_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [47:0] ACC_MIN = {1'b1, 47'd0};
  localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_KV = 1'b1;

  typedef struct packed {
    logic command;
    logic [5:0] elem_index;
    logic signed [15:0] q_elem;
    logic signed [15:0] k_elem;
    logic signed [15:0] v_elem;
    logic row_end;
    logic seq_end;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_index;
    logic signed [15:0] out_value;
    logic out_last;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic load;
    logic mac;
    logic maxs;
    logic diff;
    logic expa_s;
    logic expb_s;
    logic expa_w;
    logic expb_w;
    logic suma;
    logic sumb;
    logic sw_rd;
    logic sw_m1;
    logic sw_m2;
    logic sw_wr;
    logic em_rd;
    logic div_init;
    logic div_step;
    logic em_out;
  } cmd_t;

  typedef struct packed {
    logic cmd_kv;
    logic row_end;
    logic seq_end;
    logic j_last;
    logic div_done;
    logic out_busy;
  } sts_t;

  typedef logic [16:0] exp_tab_t [EXP_TABLE_SIZE];

  // 2^(-i/N) in Q1.16 via a Taylor series of exp(-y) in Q0.30
  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    logic [63:0] y;
    logic [63:0] term;
    longint sum;
    for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
      y = (64'(i) * LN2_Q30) / EXP_TABLE_SIZE;
      term = 64'd1 << 30;
      sum = longint'(64'd1 << 30);
      for (int k = 1; k <= 20; k++) begin
        term = ((term * y) >> 30) / 64'(k);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      tab[i] = 17'((64'(sum) + (64'd1 << 13)) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

@@ src/osa_ctrl.sv @@
`timescale 1ns / 1ps
module osa_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  osa_pkg::sts_t sts,
  output osa_pkg::cmd_t cmd
);

  typedef enum logic [18:0] {
    S_IDLE     = 19'b0000000000000000001,
    S_LOAD     = 19'b0000000000000000010,
    S_MAC      = 19'b0000000000000000100,
    S_MAXS     = 19'b0000000000000001000,
    S_DIFF     = 19'b0000000000000010000,
    S_EXPA_S   = 19'b0000000000000100000,
    S_EXPB_S   = 19'b0000000000001000000,
    S_EXPA_W   = 19'b0000000000010000000,
    S_EXPB_W   = 19'b0000000000100000000,
    S_SUMA     = 19'b0000000001000000000,
    S_SUMB     = 19'b0000000010000000000,
    S_SW_RD    = 19'b0000000100000000000,
    S_SW_M1    = 19'b0000001000000000000,
    S_SW_M2    = 19'b0000010000000000000,
    S_SW_WR    = 19'b0000100000000000000,
    S_EM_RD    = 19'b0001000000000000000,
    S_DIV_INIT = 19'b0010000000000000000,
    S_DIV_STEP = 19'b0100000000000000000,
    S_EM_OUT   = 19'b1000000000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (item_valid) state_next = S_LOAD;
      S_LOAD:     state_next = (sts.cmd_kv) ? S_MAC : S_IDLE;
      S_MAC:      state_next = (sts.row_end) ? S_MAXS : S_IDLE;
      S_MAXS:     state_next = S_DIFF;
      S_DIFF:     state_next = S_EXPA_S;
      S_EXPA_S:   state_next = S_EXPB_S;
      S_EXPB_S:   state_next = S_EXPA_W;
      S_EXPA_W:   state_next = S_EXPB_W;
      S_EXPB_W:   state_next = S_SUMA;
      S_SUMA:     state_next = S_SUMB;
      S_SUMB:     state_next = S_SW_RD;
      S_SW_RD:    state_next = S_SW_M1;
      S_SW_M1:    state_next = S_SW_M2;
      S_SW_M2:    state_next = S_SW_WR;
      S_SW_WR: begin
        if (!sts.j_last) state_next = S_SW_RD;
        else if (sts.seq_end) state_next = S_EM_RD;
        else state_next = S_IDLE;
      end
      S_EM_RD:    state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV_STEP;
      S_DIV_STEP: if (sts.div_done) state_next = S_EM_OUT;
      S_EM_OUT: begin
        if (!sts.out_busy) state_next = (sts.j_last) ? S_IDLE : S_EM_RD;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  assign item_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.latch    = (state == S_IDLE) && item_valid;
    cmd.load     = (state == S_LOAD);
    cmd.mac      = (state == S_MAC);
    cmd.maxs     = (state == S_MAXS);
    cmd.diff     = (state == S_DIFF);
    cmd.expa_s   = (state == S_EXPA_S);
    cmd.expb_s   = (state == S_EXPB_S);
    cmd.expa_w   = (state == S_EXPA_W);
    cmd.expb_w   = (state == S_EXPB_W);
    cmd.suma     = (state == S_SUMA);
    cmd.sumb     = (state == S_SUMB);
    cmd.sw_rd    = (state == S_SW_RD);
    cmd.sw_m1    = (state == S_SW_M1);
    cmd.sw_m2    = (state == S_SW_M2);
    cmd.sw_wr    = (state == S_SW_WR);
    cmd.em_rd    = (state == S_EM_RD);
    cmd.div_init = (state == S_DIV_INIT);
    cmd.div_step = (state == S_DIV_STEP);
    cmd.em_out   = (state == S_EM_OUT);
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == S_LOAD))
    else $error("accepted item not loaded");
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_STEP && !sts.div_done) |=> (state == S_DIV_STEP))
    else $error("division left early");

endmodule

@@ src/osa_dp.sv @@
`timescale 1ns / 1ps
module osa_dp (
  input  logic clk,
  input  logic rst,
  input  osa_pkg::cmd_t cmd,
  output osa_pkg::sts_t sts,
  input  osa_pkg::in_item_t item,
  input  logic [6:0] cfg_we_data,
  input  logic cfg_we_en,
  output logic result_valid,
  input  logic result_stall,
  output osa_pkg::out_item_t result
);

  osa_pkg::in_item_t item_r;
  logic [6:0] dims_in_use;
  logic [6:0] d;

  logic signed [15:0] qmem [osa_pkg::MAX_DIM];
  logic signed [15:0] vmem [osa_pkg::MAX_DIM];
  logic signed [47:0] amem [osa_pkg::MAX_DIM];
  logic [osa_pkg::MAX_DIM-1:0] acc_vld;

  logic signed [15:0] qd;
  logic signed [15:0] v_rd;
  logic signed [47:0] acc_rd;
  logic signed [39:0] partial;
  logic signed [39:0] rmax;
  logic signed [39:0] m;
  logic [40:0] mag_s;
  logic [40:0] mag_w;
  logic exp_zero;
  logic [36:0] exp_prod;
  logic [16:0] scale;
  logic [16:0] w;
  logic [31:0] rsum;
  logic [48:0] sum_prod;
  logic seen;
  logic [osa_pkg::ADDR_W-1:0] j;
  logic [32:0] p_lo;
  logic signed [33:0] p_wv;
  logic signed [49:0] p_hi;
  logic [47:0] div_q;
  logic [32:0] div_rem;
  logic [5:0] div_cnt;
  logic div_neg;

  logic j_last;
  logic idx_in_use;
  logic signed [31:0] qk;
  logic signed [40:0] score_sum;
  logic signed [39:0] score_next;
  logic [40:0] exp_mag;
  logic [16:0] exp_val;
  logic [33:0] rsum_sum;
  logic signed [50:0] acc_sum;
  logic signed [47:0] acc_next;
  logic [32:0] rem_sh;
  logic out_busy;
  logic out_load;
  logic signed [15:0] quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= 7'd64;
    end else if (cfg_we_en) begin
      dims_in_use <= cfg_we_data;
    end
  end

  always_comb begin
    if (dims_in_use == 7'd0) d = 7'd1;
    else if (dims_in_use > 7'(osa_pkg::MAX_DIM)) d = 7'(osa_pkg::MAX_DIM);
    else d = dims_in_use;
  end

  assign j_last = ({1'b0, j} == d - 7'd1);
  assign idx_in_use = ({1'b0, item_r.elem_index} < d);

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= item;
  end

  // query and value stores, registered reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (item_r.command == osa_pkg::CMD_QUERY) begin
        qmem[item_r.elem_index] <= item_r.q_elem;
      end else begin
        vmem[item_r.elem_index] <= item_r.v_elem;
        qd <= qmem[item_r.elem_index];
      end
    end
    if (cmd.sw_rd) v_rd <= vmem[j];
  end

  always_ff @(posedge clk) begin
    if (cmd.sw_wr) amem[j] <= acc_next;
    if (cmd.sw_rd || cmd.em_rd) acc_rd <= acc_vld[j] ? amem[j] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= '0;
    end else if (out_load && j_last) begin
      acc_vld <= '0;
    end else if (cmd.sw_wr) begin
      acc_vld[j] <= 1'b1;
    end
  end

  // score accumulation with saturation
  assign qk = qd * item_r.k_elem;
  assign score_sum = 41'(partial) + 41'(qk);
  always_comb begin
    if (score_sum[40] != score_sum[39]) begin
      score_next = score_sum[40] ? osa_pkg::SCORE_MIN : osa_pkg::SCORE_MAX;
    end else begin
      score_next = score_sum[39:0];
    end
  end

  // shared exp(-x) unit: multiply stage then table stage
  assign exp_mag = cmd.expa_s ? mag_s : mag_w;
  assign exp_val = exp_zero ? 17'd0 :
    (osa_pkg::EXP_TABLE[exp_prod[31 -: osa_pkg::EXP_IDX_W]] >> exp_prod[36:32]);

  always_ff @(posedge clk) begin
    if (cmd.maxs) begin
      m <= (!seen) ? partial : ((rmax > partial) ? rmax : partial);
    end
    if (cmd.diff) begin
      mag_s <= 41'(m) - 41'(rmax);
      mag_w <= 41'(m) - 41'(partial);
    end
    if (cmd.expa_s || cmd.expa_w) begin
      exp_zero <= (exp_mag >= osa_pkg::EXP_MAG_LIMIT);
      exp_prod <= 37'(exp_mag[19:0] * osa_pkg::LOG2E_Q16);
    end
    if (cmd.expb_s) scale <= seen ? exp_val : 17'd0;
    if (cmd.expb_w) w <= exp_val;
    if (cmd.suma) sum_prod <= rsum * scale;
    if (cmd.sw_m1) begin
      p_lo <= acc_rd[15:0] * scale;
      p_wv <= $signed({1'b0, w}) * v_rd;
    end
    if (cmd.sw_m2) p_hi <= $signed(acc_rd[47:16]) * $signed({1'b0, scale});
  end

  assign rsum_sum = 34'(sum_prod[48:16]) + 34'(w);
  assign acc_sum = 51'(p_hi) + 51'($signed({1'b0, p_lo[32:16]})) + 51'(p_wv);
  always_comb begin
    if (acc_sum > 51'(osa_pkg::ACC_MAX)) acc_next = osa_pkg::ACC_MAX;
    else if (acc_sum < 51'(osa_pkg::ACC_MIN)) acc_next = osa_pkg::ACC_MIN;
    else acc_next = acc_sum[47:0];
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      rmax <= osa_pkg::SCORE_MIN;
      rsum <= '0;
      seen <= 1'b0;
    end else if (out_load && j_last) begin
      partial <= '0;
      rmax <= osa_pkg::SCORE_MIN;
      rsum <= '0;
      seen <= 1'b0;
    end else begin
      if (cmd.mac && idx_in_use) partial <= score_next;
      if (cmd.sumb) rsum <= (rsum_sum[33:32] != 2'd0) ? '1 : rsum_sum[31:0];
      if (cmd.sw_wr && j_last) begin
        rmax <= m;
        seen <= 1'b1;
        partial <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (cmd.sumb) begin
      j <= '0;
    end else if (cmd.sw_wr || out_load) begin
      j <= j_last ? '0 : j + 1'b1;
    end
  end

  // restoring divider on magnitudes, one quotient bit per cycle
  assign rem_sh = {div_rem[31:0], div_q[47]};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_neg <= acc_rd[47];
      div_q <= acc_rd[47] ? 48'(-acc_rd) : acc_rd;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 6'd1;
      if (rem_sh >= {1'b0, rsum}) begin
        div_rem <= rem_sh - {1'b0, rsum};
        div_q <= {div_q[46:0], 1'b1};
      end else begin
        div_rem <= rem_sh;
        div_q <= {div_q[46:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (rsum == '0) quot = '0;
    else if (div_neg) quot = (div_q > 48'd32768) ? -16'sd32768 : 16'(-div_q);
    else quot = (div_q > 48'd32767) ? 16'sd32767 : 16'(div_q);
  end

  assign out_busy = result_valid && result_stall;
  assign out_load = cmd.em_out && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.out_index <= j;
      result.out_value <= quot;
      result.out_last <= j_last;
    end
  end

  always_comb begin
    sts.cmd_kv = (item_r.command == osa_pkg::CMD_KV);
    sts.row_end = item_r.row_end;
    sts.seq_end = item_r.seq_end;
    sts.j_last = j_last;
    sts.div_done = (div_cnt == 6'd47);
    sts.out_busy = out_busy;
  end

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.em_out))
    else $error("result raised outside emission");
  a_seen_after_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.sw_wr && j_last) |=> seen)
    else $error("row completion not recorded");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

@@ src/online_softmax_attention_core.sv @@
`timescale 1ns / 1ps
// query element: load into the query store; key/value element without row end: load, then a MAC step
// row end: max, exponent and sum steps, then the accumulator sweep through the single-port store
// last row adds per-element output through the bit-serial divider, held back by output stalls
// one item in flight; stall is low only while the controller is idle
// reset (synchronous, high): controller idle, d = 64, sequence state cleared;
// query and value stores are undefined until written
module online_softmax_attention_core (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  osa_pkg::in_item_t item,
  output logic result_valid,
  input  logic result_stall,
  output osa_pkg::out_item_t result,
  input  logic cfg_we,
  input  logic [6:0] cfg_data
);

  osa_pkg::cmd_t cmd;
  osa_pkg::sts_t sts;

  osa_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .sts(sts),
    .cmd(cmd)
  );

  osa_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .item(item),
    .cfg_we_data(cfg_data),
    .cfg_we_en(cfg_we),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule
